>>> hdl/tlpeq_pkg.sv
// Shared types, constants and field layout of the two-level priority event queue.
package tlpeq_pkg;

   // Default sizes handed to the top level
   localparam int DEFAULT_QUEUE_DEPTH   = 16;
   localparam int DEFAULT_PAYLOAD_WIDTH = 32;

   // Fixed widths of the request and response fields
   localparam int EVENT_W     = 32;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   // Response tdata bit positions
   localparam int RSP_ACCEPTED_BIT = 0;
   localparam int RSP_EVALID_BIT   = 1;
   localparam int RSP_EPRIO_BIT    = 2;
   localparam int RSP_EPAY_LSB     = 3;
   localparam int RSP_BUSY_BIT     = RSP_EPAY_LSB + EVENT_W;
   localparam int RSP_PREEMPT_BIT  = RSP_BUSY_BIT + 1;
   localparam int RSP_HCOUNT_LSB   = RSP_PREEMPT_BIT + 1;
   localparam int RSP_LCOUNT_LSB   = RSP_HCOUNT_LSB + COUNT_W;

   // Priority codes
   localparam logic PRIO_HIGH = 1'b0;
   localparam logic PRIO_LOW  = 1'b1;

   // Request kinds
   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DISPATCH = 2'd1,
      OP_DONE     = 2'd2,
      OP_NOP      = 2'd3
   } op_type;

   // Result of one request, known at acceptance; payload follows from the RAM
   typedef struct packed {
      logic               accepted;
      logic               event_valid;
      logic               event_priority;
      logic               busy;
      logic               preempt;
      logic [COUNT_W-1:0] high_count;
      logic [COUNT_W-1:0] low_count;
   } result_meta_type;

endpackage

>>> hdl/tlpeq_ring_mem.sv
// Ring storage of one queue: single write port, one read port with registered data.
module tlpeq_ring_mem #(
   parameter int DEPTH = tlpeq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int WIDTH = tlpeq_pkg::DEFAULT_PAYLOAD_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
   end

   // read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tlpeq_ctrl.sv
// Queue pointers, fill counts, run/preempt flags and RAM access decode per request.
module tlpeq_ctrl #(
   parameter int QUEUE_DEPTH   = tlpeq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PAYLOAD_WIDTH = tlpeq_pkg::DEFAULT_PAYLOAD_WIDTH,
   parameter int PTR_W         = $clog2(QUEUE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  tlpeq_pkg::op_type             req_op,
   input  logic                          req_prio,
   input  logic [tlpeq_pkg::EVENT_W-1:0] req_payload,
   output logic                          hi_wr_en,
   output logic                          lo_wr_en,
   output logic [PTR_W-1:0]              wr_addr,
   output logic [PAYLOAD_WIDTH-1:0]      wr_data,
   output logic                          hi_rd_en,
   output logic                          lo_rd_en,
   output logic [PTR_W-1:0]              hi_rd_addr,
   output logic [PTR_W-1:0]              lo_rd_addr,
   output tlpeq_pkg::result_meta_type    meta
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

   logic [PTR_W-1:0]  hi_rd_ff, hi_rd_in, hi_wr_ff, hi_wr_in;
   logic [PTR_W-1:0]  lo_rd_ff, lo_rd_in, lo_wr_ff, lo_wr_in;
   logic [FILL_W-1:0] hi_fill_ff, hi_fill_in, lo_fill_ff, lo_fill_in;
   logic              running_ff, running_in;
   logic              run_prio_ff, run_prio_in;
   logic              preempt_ff, preempt_in;
   logic              acc, ev_valid, ev_prio;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // request decode and next state
   always_comb begin
      hi_rd_in    = hi_rd_ff;
      hi_wr_in    = hi_wr_ff;
      hi_fill_in  = hi_fill_ff;
      lo_rd_in    = lo_rd_ff;
      lo_wr_in    = lo_wr_ff;
      lo_fill_in  = lo_fill_ff;
      running_in  = running_ff;
      run_prio_in = run_prio_ff;
      preempt_in  = preempt_ff;
      acc         = 1'b0;
      ev_valid    = 1'b0;
      ev_prio     = tlpeq_pkg::PRIO_HIGH;
      hi_wr_en    = 1'b0;
      lo_wr_en    = 1'b0;
      hi_rd_en    = 1'b0;
      lo_rd_en    = 1'b0;
      wr_addr     = (req_prio == tlpeq_pkg::PRIO_HIGH) ? hi_wr_ff : lo_wr_ff;
      if (req_accept) begin
         unique case (req_op)
            tlpeq_pkg::OP_ADD: begin
               if (req_prio == tlpeq_pkg::PRIO_HIGH) begin
                  if (hi_fill_ff != FILL_MAX) begin
                     acc        = 1'b1;
                     hi_wr_en   = 1'b1;
                     hi_wr_in   = ptr_next(hi_wr_ff);
                     hi_fill_in = hi_fill_ff + 1'b1;
                     if (running_ff && run_prio_ff == tlpeq_pkg::PRIO_LOW) begin
                        preempt_in = 1'b1;
                     end
                  end
               end else begin
                  if (lo_fill_ff != FILL_MAX) begin
                     acc        = 1'b1;
                     lo_wr_en   = 1'b1;
                     lo_wr_in   = ptr_next(lo_wr_ff);
                     lo_fill_in = lo_fill_ff + 1'b1;
                  end
               end
            end
            tlpeq_pkg::OP_DISPATCH: begin
               if (!running_ff) begin
                  if (hi_fill_ff != '0) begin
                     hi_rd_en   = 1'b1;
                     hi_rd_in   = ptr_next(hi_rd_ff);
                     hi_fill_in = hi_fill_ff - 1'b1;
                     ev_valid   = 1'b1;
                     ev_prio    = tlpeq_pkg::PRIO_HIGH;
                  end else if (lo_fill_ff != '0) begin
                     lo_rd_en   = 1'b1;
                     lo_rd_in   = ptr_next(lo_rd_ff);
                     lo_fill_in = lo_fill_ff - 1'b1;
                     ev_valid   = 1'b1;
                     ev_prio    = tlpeq_pkg::PRIO_LOW;
                  end
                  if (ev_valid) begin
                     acc         = 1'b1;
                     running_in  = 1'b1;
                     run_prio_in = ev_prio;
                  end
               end
            end
            tlpeq_pkg::OP_DONE: begin
               acc         = running_ff;
               running_in  = 1'b0;
               run_prio_in = tlpeq_pkg::PRIO_HIGH;
               preempt_in  = 1'b0;
            end
            tlpeq_pkg::OP_NOP: begin
               acc = 1'b0;
            end
            default: begin
               acc = 1'b0;
            end
         endcase
      end
   end

   assign wr_data    = PAYLOAD_WIDTH'(req_payload);
   assign hi_rd_addr = hi_rd_ff;
   assign lo_rd_addr = lo_rd_ff;

   // result fields that follow from the updated state
   always_comb begin
      meta.accepted       = acc;
      meta.event_valid    = ev_valid;
      meta.event_priority = ev_prio;
      meta.busy           = running_in;
      meta.preempt        = preempt_in;
      meta.high_count     = tlpeq_pkg::COUNT_W'(hi_fill_in);
      meta.low_count      = tlpeq_pkg::COUNT_W'(lo_fill_in);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hi_rd_ff    <= '0;
         hi_wr_ff    <= '0;
         hi_fill_ff  <= '0;
         lo_rd_ff    <= '0;
         lo_wr_ff    <= '0;
         lo_fill_ff  <= '0;
         running_ff  <= 1'b0;
         run_prio_ff <= tlpeq_pkg::PRIO_HIGH;
         preempt_ff  <= 1'b0;
      end else begin
         hi_rd_ff    <= hi_rd_in;
         hi_wr_ff    <= hi_wr_in;
         hi_fill_ff  <= hi_fill_in;
         lo_rd_ff    <= lo_rd_in;
         lo_wr_ff    <= lo_wr_in;
         lo_fill_ff  <= lo_fill_in;
         running_ff  <= running_in;
         run_prio_ff <= run_prio_in;
         preempt_ff  <= preempt_in;
      end
   end

endmodule

>>> hdl/two_level_priority_event_queue_core.sv
// Top level of the two-level priority event queue: handshake, RAMs and response register.
//
// Requests arrive on the req_ stream: req_tuser carries the kind (add, dispatch,
// done, no-op), req_tdata the priority of an add and its payload word. Every
// request yields exactly one response on the rsp_ stream, in order.
// A request updates pointers, counts and flags in the cycle it is accepted and
// starts at most one access of the high or low queue RAM at that same edge. The RAM
// read data is there in the following cycle, and the response register loads from
// the pending stage when it is free or draining, and rsp_tvalid then rises.
// Throughput is one request per cycle while rsp_tready stays high; the RAM
// read latency sits in a one-entry pending stage, not in the request path.
// When the receiver stalls, the response holds and one more request may be
// taken into the pending stage; req_tready then drops until the response moves.
// Reset (synchronous, active high) empties both queues, clears busy and preempt
// and drops both valid flags; queue RAM contents are not cleared and need not be,
// since an entry is only read after it was written.
module two_level_priority_event_queue_core #(
   parameter int QUEUE_DEPTH   = tlpeq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int PAYLOAD_WIDTH = tlpeq_pkg::DEFAULT_PAYLOAD_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] priority_req, [32:1] payload, [39:33] zero
   input  logic [tlpeq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] accepted, [1] event_valid, [2] event_priority, [34:3] event_payload,
   // [35] busy_res, [36] preempt, [41:37] high_count, [46:42] low_count, [47] zero
   output logic [tlpeq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic                          req_accept, out_load;
   logic                          pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tlpeq_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   tlpeq_pkg::result_meta_type    meta, meta_ff;
   logic                          hi_wr_en, lo_wr_en, hi_rd_en, lo_rd_en;
   logic [PTR_W-1:0]              wr_addr, hi_rd_addr, lo_rd_addr;
   logic [PAYLOAD_WIDTH-1:0]      wr_data, hi_rd_data, lo_rd_data;
   logic [tlpeq_pkg::EVENT_W-1:0] ev_payload;

   // handshake: response register free or draining this cycle
   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pend_ff || out_load;
   assign req_accept = req_tvalid && req_tready;

   tlpeq_ctrl #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .req_op      (tlpeq_pkg::op_type'(req_tuser)),
      .req_prio    (req_tdata[0]),
      .req_payload (req_tdata[tlpeq_pkg::EVENT_W:1]),
      .hi_wr_en    (hi_wr_en),
      .lo_wr_en    (lo_wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .hi_rd_en    (hi_rd_en),
      .lo_rd_en    (lo_rd_en),
      .hi_rd_addr  (hi_rd_addr),
      .lo_rd_addr  (lo_rd_addr),
      .meta        (meta)
   );

   tlpeq_ring_mem #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (PAYLOAD_WIDTH)
   ) u_high_mem (
      .clock   (clock),
      .wr_en   (hi_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (hi_rd_en),
      .rd_addr (hi_rd_addr),
      .rd_data (hi_rd_data)
   );

   tlpeq_ring_mem #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (PAYLOAD_WIDTH)
   ) u_low_mem (
      .clock   (clock),
      .wr_en   (lo_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (lo_rd_en),
      .rd_addr (lo_rd_addr),
      .rd_data (lo_rd_data)
   );

   // pending stage waits for RAM read data
   always_comb begin
      if (req_accept) begin
         pend_in = 1'b1;
      end else if (out_load) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   // response assembly
   always_comb begin
      if (!meta_ff.event_valid) begin
         ev_payload = '0;
      end else if (meta_ff.event_priority == tlpeq_pkg::PRIO_LOW) begin
         ev_payload = tlpeq_pkg::EVENT_W'(lo_rd_data);
      end else begin
         ev_payload = tlpeq_pkg::EVENT_W'(hi_rd_data);
      end
      rsp_data_in = {1'b0, meta_ff.low_count, meta_ff.high_count, meta_ff.preempt,
                     meta_ff.busy, ev_payload, meta_ff.event_priority,
                     meta_ff.event_valid, meta_ff.accepted};
      if (pend_ff && out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         meta_ff <= meta;
      end
      if (pend_ff && out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/tlpeq_checker.sv
// Port-level checker of the two-level priority event queue, bound to the top level.
module tlpeq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tlpeq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // a presented event is always an accepted dispatch
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[tlpeq_pkg::RSP_EVALID_BIT]
      |-> rsp_tdata[tlpeq_pkg::RSP_ACCEPTED_BIT] && rsp_tdata[tlpeq_pkg::RSP_BUSY_BIT])
      else $error("event presented without accept or busy");

   // preempt only while an event runs
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[tlpeq_pkg::RSP_PREEMPT_BIT]
      |-> rsp_tdata[tlpeq_pkg::RSP_BUSY_BIT])
      else $error("preempt set while idle");

   // no event: priority and payload are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[tlpeq_pkg::RSP_EVALID_BIT]
      |-> !rsp_tdata[tlpeq_pkg::RSP_EPRIO_BIT]
          && rsp_tdata[tlpeq_pkg::RSP_BUSY_BIT-1:tlpeq_pkg::RSP_EPAY_LSB] == '0)
      else $error("event fields not cleared without event");

endmodule

bind two_level_priority_event_queue_core tlpeq_checker u_tlpeq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/tb.sv
// Self-checking stream testbench for the two-level priority event queue core.
module tb;

   localparam int DEPTH        = tlpeq_pkg::DEFAULT_QUEUE_DEPTH;
   localparam int RANDOM_ITEMS = 1100;
   localparam int TAIL_ITEMS   = 100;

   // Request as queued for the driver
   typedef struct {
      tlpeq_pkg::op_type op;
      logic              prio;
      logic [31:0]       payload;
   } request_type;

   // One response, field by field
   typedef struct {
      logic         accepted;
      logic         event_valid;
      logic         event_priority;
      logic [31:0]  event_payload;
      logic         busy;
      logic         preempt;
      logic [4:0]   high_count;
      logic [4:0]   low_count;
   } outcome_type;

   typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} segment_kind_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [tlpeq_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]                        req_tuser  = tlpeq_pkg::OP_NOP;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tlpeq_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   two_level_priority_event_queue_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   request_type pending_requests[$];
   outcome_type expected_outcomes[$];
   int          fail_count     = 0;
   int          request_count  = 0;
   int          dispatch_count = 0;
   int          refused_adds   = 0;
   int          preempt_raises = 0;
   int          send_gap       = 0;
   int          recv_gap       = 0;

   // Shadow state of both rings and the run flags
   logic [31:0] high_ring[DEPTH];
   logic [31:0] low_ring[DEPTH];
   int          high_rd = 0, high_wr = 0, high_fill = 0;
   int          low_rd = 0, low_wr = 0, low_fill = 0;
   logic        busy_now = 1'b0;
   logic        busy_is_low = tlpeq_pkg::PRIO_HIGH;
   logic        preempt_raised = 1'b0;

   // Apply one request to the shadow queues and return the response it yields
   function automatic outcome_type step_event_queue(request_type r);
      outcome_type o;
      o = '{default: '0};
      case (r.op)
         tlpeq_pkg::OP_ADD: begin
            if (r.prio == tlpeq_pkg::PRIO_HIGH) begin
               if (high_fill < DEPTH) begin
                  high_ring[high_wr] = r.payload;
                  high_wr = (high_wr + 1) % DEPTH;
                  high_fill++;
                  o.accepted = 1'b1;
                  if (busy_now && busy_is_low == tlpeq_pkg::PRIO_LOW) preempt_raised = 1'b1;
               end
            end else if (low_fill < DEPTH) begin
               low_ring[low_wr] = r.payload;
               low_wr = (low_wr + 1) % DEPTH;
               low_fill++;
               o.accepted = 1'b1;
            end
         end
         tlpeq_pkg::OP_DISPATCH: begin
            if (!busy_now) begin
               // strict priority: high ring first
               if (high_fill > 0) begin
                  o.event_payload  = high_ring[high_rd];
                  o.event_priority = tlpeq_pkg::PRIO_HIGH;
                  o.event_valid    = 1'b1;
                  high_rd = (high_rd + 1) % DEPTH;
                  high_fill--;
               end else if (low_fill > 0) begin
                  o.event_payload  = low_ring[low_rd];
                  o.event_priority = tlpeq_pkg::PRIO_LOW;
                  o.event_valid    = 1'b1;
                  low_rd = (low_rd + 1) % DEPTH;
                  low_fill--;
               end
               if (o.event_valid) begin
                  o.accepted  = 1'b1;
                  busy_now    = 1'b1;
                  busy_is_low = o.event_priority;
               end
            end
         end
         tlpeq_pkg::OP_DONE: begin
            o.accepted     = busy_now;
            busy_now       = 1'b0;
            busy_is_low    = tlpeq_pkg::PRIO_HIGH;
            preempt_raised = 1'b0;
         end
         default: ;
      endcase
      o.busy       = busy_now;
      o.preempt    = preempt_raised;
      o.high_count = 5'(high_fill);
      o.low_count  = 5'(low_fill);
      return o;
   endfunction

   function automatic void queue_request(tlpeq_pkg::op_type op, logic prio,
                                         logic [31:0] payload);
      request_type r;
      r.op      = op;
      r.prio    = prio;
      r.payload = payload;
      pending_requests.push_back(r);
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Driver: presents the head of the pending list, idles in random bursts
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_type o;
            o = step_event_queue(pending_requests[0]);
            if (pending_requests[0].op == tlpeq_pkg::OP_ADD && !o.accepted) refused_adds++;
            expected_outcomes.push_back(o);
            pending_requests.pop_front();
            request_count++;
         end
         // hold a stalled request; otherwise choose the next cycle
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 15) == 0) begin
               send_gap = $urandom_range(0, 14);
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_requests[0].op;
               req_tdata  <= {{(tlpeq_pkg::REQ_TDATA_W - tlpeq_pkg::EVENT_W - 1){1'b0}},
                              pending_requests[0].payload, pending_requests[0].prio};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response against the oldest expectation, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            outcome_type got, exp_o;
            got.accepted       = rsp_tdata[tlpeq_pkg::RSP_ACCEPTED_BIT];
            got.event_valid    = rsp_tdata[tlpeq_pkg::RSP_EVALID_BIT];
            got.event_priority = rsp_tdata[tlpeq_pkg::RSP_EPRIO_BIT];
            got.event_payload  = rsp_tdata[tlpeq_pkg::RSP_EPAY_LSB +: tlpeq_pkg::EVENT_W];
            got.busy           = rsp_tdata[tlpeq_pkg::RSP_BUSY_BIT];
            got.preempt        = rsp_tdata[tlpeq_pkg::RSP_PREEMPT_BIT];
            got.high_count     = rsp_tdata[tlpeq_pkg::RSP_HCOUNT_LSB +: tlpeq_pkg::COUNT_W];
            got.low_count      = rsp_tdata[tlpeq_pkg::RSP_LCOUNT_LSB +: tlpeq_pkg::COUNT_W];
            if (expected_outcomes.size() == 0) begin
               $error("response with no request outstanding: tdata %0h", rsp_tdata);
               fail_count++;
            end else begin
               exp_o = expected_outcomes.pop_front();
               check_field("accepted", 32'(exp_o.accepted), 32'(got.accepted));
               check_field("event_valid", 32'(exp_o.event_valid), 32'(got.event_valid));
               check_field("event_priority", 32'(exp_o.event_priority),
                           32'(got.event_priority));
               check_field("event_payload", exp_o.event_payload, got.event_payload);
               check_field("busy_res", 32'(exp_o.busy), 32'(got.busy));
               check_field("preempt", 32'(exp_o.preempt), 32'(got.preempt));
               check_field("high_count", 32'(exp_o.high_count), 32'(got.high_count));
               check_field("low_count", 32'(exp_o.low_count), 32'(got.low_count));
               if (exp_o.event_valid) dispatch_count++;
               if (exp_o.preempt) preempt_raises++;
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (pending_requests.size() > TAIL_ITEMS && $urandom_range(0, 15) == 0) begin
            recv_gap = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run
   initial begin
      segment_kind_type  seg;
      int                seg_len;
      int                low_bias;
      int                roll;
      logic              prio;
      logic [31:0]       payload;
      tlpeq_pkg::op_type op;

      // directed: empty and idle corners, busy refusal, preemption, full high ring
      queue_request(tlpeq_pkg::OP_DISPATCH, tlpeq_pkg::PRIO_HIGH, 32'h0);
      queue_request(tlpeq_pkg::OP_DONE, tlpeq_pkg::PRIO_LOW, 32'hFFFF_FFFF);
      queue_request(tlpeq_pkg::OP_NOP, tlpeq_pkg::PRIO_LOW, 32'hFFFF_FFFF);
      queue_request(tlpeq_pkg::OP_ADD, tlpeq_pkg::PRIO_LOW, 32'hFFFF_FFFF);
      queue_request(tlpeq_pkg::OP_DISPATCH, tlpeq_pkg::PRIO_LOW, 32'h0);
      queue_request(tlpeq_pkg::OP_ADD, tlpeq_pkg::PRIO_HIGH, 32'h0);
      queue_request(tlpeq_pkg::OP_DISPATCH, tlpeq_pkg::PRIO_HIGH, 32'h0);
      queue_request(tlpeq_pkg::OP_DONE, tlpeq_pkg::PRIO_HIGH, 32'h0);
      for (int i = 0; i < DEPTH - 1; i++)
         queue_request(tlpeq_pkg::OP_ADD, tlpeq_pkg::PRIO_HIGH,
                       (i % 2) ? 32'hAAAA_5555 : 32'h5555_AAAA);
      queue_request(tlpeq_pkg::OP_ADD, tlpeq_pkg::PRIO_HIGH, 32'hDEAD_0001);
      queue_request(tlpeq_pkg::OP_DISPATCH, tlpeq_pkg::PRIO_LOW, 32'h0);

      // random segments: fill-heavy, drain-heavy and mixed, with a per-segment priority bias
      while (pending_requests.size() < RANDOM_ITEMS + 25) begin
         seg      = segment_kind_type'($urandom_range(0, 2));
         seg_len  = $urandom_range(8, 40);
         low_bias = $urandom_range(0, 100);
         repeat (seg_len) begin
            roll = $urandom_range(0, 99);
            prio = ($urandom_range(0, 99) < low_bias) ? tlpeq_pkg::PRIO_LOW
                                                      : tlpeq_pkg::PRIO_HIGH;
            case ($urandom_range(0, 9))
               0:       payload = 32'h0;
               1:       payload = 32'hFFFF_FFFF;
               default: payload = $urandom;
            endcase
            case (seg)
               SEG_FILL:  op = (roll < 85) ? tlpeq_pkg::OP_ADD :
                               (roll < 92) ? tlpeq_pkg::OP_DISPATCH :
                               (roll < 97) ? tlpeq_pkg::OP_DONE : tlpeq_pkg::OP_NOP;
               SEG_DRAIN: op = (roll < 20) ? tlpeq_pkg::OP_ADD :
                               (roll < 60) ? tlpeq_pkg::OP_DISPATCH :
                               (roll < 96) ? tlpeq_pkg::OP_DONE : tlpeq_pkg::OP_NOP;
               default:   op = (roll < 40) ? tlpeq_pkg::OP_ADD :
                               (roll < 70) ? tlpeq_pkg::OP_DISPATCH :
                               (roll < 95) ? tlpeq_pkg::OP_DONE : tlpeq_pkg::OP_NOP;
            endcase
            queue_request(op, prio, payload);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || expected_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d requests: %0d events dispatched, %0d adds refused on a full ring,",
               request_count, dispatch_count, refused_adds);
      $display("%0d responses with preempt set, under random stalls on both streams.",
               preempt_raises);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

endmodule
